// ===== rtl/arc_pkg.sv =====
// shared codes, widths and types for the add-rotate cbc cipher
`timescale 1ns / 1ps
`default_nettype none

package arc_pkg;

  localparam int WordW = 32;
  localparam int DataW = 64;

  localparam logic [1:0] OP_ENC = 2'd0;
  localparam logic [1:0] OP_DEC = 2'd1;
  localparam logic [1:0] OP_KEY = 2'd2;

  localparam logic [1:0] KIND_BLOCK = 2'd0;
  localparam logic [1:0] KIND_WORD  = 2'd1;
  localparam logic [1:0] KIND_BYTE  = 2'd2;

  localparam logic [WordW-1:0] BYTE_MASK = 32'h0000_00FF;

  typedef struct packed {
    logic       inverse;
    logic [4:0] amt;
  } alu_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/arc_alu.sv =====
// shared add-rotate / rotate-subtract unit
`timescale 1ns / 1ps
`default_nettype none

module arc_alu import arc_pkg::*; (
  input  wire logic [WordW-1:0] a_i,
  input  wire logic [WordW-1:0] k_i,
  input  wire logic [WordW-1:0] c_i,
  input  wire alu_ctl_t         ctl_i,
  output logic      [WordW-1:0] r_o
);

  logic [WordW-1:0]   sum;
  logic [2*WordW-1:0] dbl_l;
  logic [2*WordW-1:0] dbl_r;
  logic [WordW-1:0]   rot_r;

  always_comb begin
    sum   = a_i + k_i + c_i;
    dbl_l = {sum, sum} << ctl_i.amt;
    dbl_r = {a_i, a_i} >> ctl_i.amt;
    rot_r = dbl_r[WordW-1:0];
    if (ctl_i.inverse) begin
      r_o = rot_r - k_i - c_i;
    end else begin
      r_o = dbl_l[2*WordW-1:WordW];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/arc_key_store.sv =====
// round key memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module arc_key_store import arc_pkg::*; #(
  parameter int Depth = 20,
  parameter int AddrW = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WordW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WordW-1:0] rdata_o
);

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/add_rotate_cbc_cipher.sv =====
// top level: sequencer, chaining state and output register of the cipher
//
// input channel: in_valid_i / in_ready_o with operation, packet_start,
// unit_kind, key_slot and data_in. output channel: out_valid_o /
// out_ready_i with data_out and out_kind.
// a key load is taken while idle and gives no result.
// an encrypt unit, or a block decrypt, runs 2*(ROUND_KEY_COUNT/2) steps
// of the shared add-rotate unit, one round key read per step. a tail word
// or byte decrypt first sums the odd keys, ROUND_KEY_COUNT/2 more steps.
// in_ready_o is high only while the sequencer is idle; one unit is in
// work at a time.
// the result sits in an output register; if the receiver stalls, the
// finished unit waits in its last state until the register frees, while
// a unit already shown stays put until its transfer.
// reset clears both chaining words and the control state; round keys
// are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module add_rotate_cbc_cipher import arc_pkg::*; #(
  parameter int ROUND_KEY_COUNT = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       operation_i,
  input  wire logic             packet_start_i,
  input  wire logic [1:0]       unit_kind_i,
  input  wire logic [4:0]       key_slot_i,
  input  wire logic [DataW-1:0] data_in_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [DataW-1:0] data_out_o,
  output logic      [1:0]       out_kind_o
);

  localparam int KW          = $clog2(ROUND_KEY_COUNT);
  localparam int ROUND_PAIRS = ROUND_KEY_COUNT / 2;
  localparam logic [KW-1:0] LAST_STEP = KW'(2 * ROUND_PAIRS - 1);
  localparam logic [KW-1:0] SUM_LAST  = KW'(ROUND_PAIRS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [KW-1:0]    step_q, step_d;
  logic             enc_q, enc_d;
  logic [1:0]       kind_q, kind_d;
  logic [WordW-1:0] x_q, x_d;
  logic [WordW-1:0] y_q, y_d;
  logic [WordW-1:0] save_lo_q, save_lo_d;
  logic [WordW-1:0] save_hi_q, save_hi_d;
  logic [WordW-1:0] chain_lo_q, chain_lo_d;
  logic [WordW-1:0] chain_hi_q, chain_hi_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;
  logic [1:0]       out_kind_q, out_kind_d;

  logic             in_fire;
  logic             is_unit;
  logic             slot_ok;
  logic             key_we;
  logic             dest_y;
  logic [WordW-1:0] cl, ch;
  logic [WordW-1:0] d_lo, d_hi;
  logic [WordW-1:0] alu_a, alu_c, alu_r;
  logic [WordW-1:0] key;
  logic [KW-1:0]    raddr;
  alu_ctl_t         alu_ctl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_unit    = (operation_i == OP_ENC || operation_i == OP_DEC)
                    && (unit_kind_i inside {KIND_BLOCK, KIND_WORD, KIND_BYTE});
  assign slot_ok    = {2'b00, key_slot_i} < 7'(ROUND_KEY_COUNT);
  assign key_we     = in_fire && (operation_i == OP_KEY) && slot_ok;

  assign cl   = packet_start_i ? '0 : chain_lo_q;
  assign ch   = packet_start_i ? '0 : chain_hi_q;
  assign d_lo = data_in_i[WordW-1:0];
  assign d_hi = data_in_i[DataW-1:WordW];

  assign dest_y = enc_q ? step_q[0] : ~step_q[0];

  arc_key_store #(
    .Depth (ROUND_KEY_COUNT),
    .AddrW (KW)
  ) u_keys (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (KW'(key_slot_i)),
    .wdata_i (d_lo),
    .raddr_i (raddr),
    .rdata_o (key)
  );

  arc_alu u_alu (
    .a_i   (alu_a),
    .k_i   (key),
    .c_i   (alu_c),
    .ctl_i (alu_ctl),
    .r_o   (alu_r)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_a           = y_q;
    alu_c           = '0;
    alu_ctl.inverse = 1'b0;
    alu_ctl.amt     = '0;
    if (state_q == ST_RUN) begin
      alu_a           = dest_y ? y_q : x_q;
      alu_ctl.inverse = ~enc_q;
      case (kind_q)
        KIND_BLOCK: alu_ctl.amt = dest_y ? x_q[4:0] : y_q[4:0];
        KIND_WORD:  alu_ctl.amt = dest_y ? 5'd0 : y_q[4:0];
        KIND_BYTE:  alu_c       = dest_y ? '0 : y_q;
        default:    alu_ctl.amt = '0;
      endcase
    end
  end

  // key prefetch address for the step that comes next
  always_comb begin
    if (state_d == ST_SUM) begin
      raddr = (step_d << 1) | KW'(1);
    end else if (enc_d) begin
      raddr = step_d;
    end else begin
      raddr = LAST_STEP - step_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    enc_d       = enc_q;
    kind_d      = kind_q;
    x_d         = x_q;
    y_d         = y_q;
    save_lo_d   = save_lo_q;
    save_hi_d   = save_hi_q;
    chain_lo_d  = chain_lo_q;
    chain_hi_d  = chain_hi_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire && is_unit) begin
          enc_d      = (operation_i == OP_ENC);
          kind_d     = unit_kind_i;
          step_d     = '0;
          chain_lo_d = cl;
          chain_hi_d = ch;
          save_lo_d  = d_lo;
          save_hi_d  = d_hi;
          y_d        = ch;
          state_d    = ST_RUN;
          case (unit_kind_i)
            KIND_BLOCK: begin
              x_d = (operation_i == OP_ENC) ? (d_lo ^ cl) : d_lo;
              y_d = (operation_i == OP_ENC) ? (d_hi ^ ch) : d_hi;
            end
            KIND_WORD: begin
              x_d = (operation_i == OP_ENC) ? (d_lo ^ cl) : d_lo;
              if (operation_i == OP_DEC) begin
                state_d = ST_SUM;
              end
            end
            default: begin
              x_d       = ((operation_i == OP_ENC) ? (d_lo ^ cl) : d_lo) & BYTE_MASK;
              save_lo_d = d_lo & BYTE_MASK;
              if (operation_i == OP_DEC) begin
                state_d = ST_SUM;
              end
            end
          endcase
        end
      end
      ST_SUM: begin
        y_d = alu_r;
        if (step_q == SUM_LAST) begin
          chain_hi_d = alu_r;
          step_d     = '0;
          state_d    = ST_RUN;
        end else begin
          step_d = step_q + KW'(1);
        end
      end
      ST_RUN: begin
        if (dest_y) begin
          y_d = alu_r;
        end else begin
          x_d = (kind_q == KIND_BYTE) ? (alu_r & BYTE_MASK) : alu_r;
        end
        if (step_q == LAST_STEP) begin
          state_d = ST_FIN;
        end else begin
          step_d = step_q + KW'(1);
        end
      end
      default: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          state_d     = ST_IDLE;
          case (kind_q)
            KIND_BLOCK: begin
              if (enc_q) begin
                out_data_d = {y_q, x_q};
                chain_lo_d = x_q;
                chain_hi_d = y_q;
              end else begin
                out_data_d = {y_q ^ chain_hi_q, x_q ^ chain_lo_q};
                chain_lo_d = save_lo_q;
                chain_hi_d = save_hi_q;
              end
            end
            KIND_WORD: begin
              if (enc_q) begin
                out_data_d = {32'd0, x_q};
                chain_lo_d = x_q;
                chain_hi_d = y_q;
              end else begin
                out_data_d = {32'd0, x_q ^ chain_lo_q};
                chain_lo_d = save_lo_q;
              end
            end
            default: begin
              if (enc_q) begin
                out_data_d = {56'd0, x_q[7:0]};
                chain_lo_d = x_q;
                chain_hi_d = y_q;
              end else begin
                out_data_d = {56'd0, x_q[7:0] ^ chain_lo_q[7:0]};
                chain_lo_d = save_lo_q;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      enc_q       <= 1'b0;
      kind_q      <= KIND_BLOCK;
      chain_lo_q  <= '0;
      chain_hi_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      enc_q       <= enc_d;
      kind_q      <= kind_d;
      chain_lo_q  <= chain_lo_d;
      chain_hi_q  <= chain_hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    save_lo_q  <= save_lo_d;
    save_hi_q  <= save_hi_d;
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign out_kind_o  = out_kind_q;

endmodule

`default_nettype wire

// ===== rtl/arc_checker.sv =====
// port-level checks for the cipher, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module arc_checker import arc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic [1:0]       operation_i,
  input wire logic             packet_start_i,
  input wire logic [1:0]       unit_kind_i,
  input wire logic [4:0]       key_slot_i,
  input wire logic [DataW-1:0] data_in_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [DataW-1:0] data_out_o,
  input wire logic [1:0]       out_kind_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_out_o)
      && $stable(out_kind_o))
    else $error("stalled result changed");

  // a unit transfer blocks the input side for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == OP_ENC || operation_i == OP_DEC)
      && (unit_kind_i == KIND_BLOCK || unit_kind_i == KIND_WORD
          || unit_kind_i == KIND_BYTE) |=> !in_ready_o)
    else $error("input ready during unit work");

  // a key load keeps the input side open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == OP_KEY |=> in_ready_o)
    else $error("key load blocked input");

  // tail results carry zero upper bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_WORD |-> data_out_o[DataW-1:WordW] == '0)
    else $error("tail word upper bits set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_kind_o != KIND_BYTE || data_out_o[DataW-1:8] == '0)
      && (out_kind_o == KIND_BLOCK || out_kind_o == KIND_WORD
          || out_kind_o == KIND_BYTE))
    else $error("bad tail byte result");

endmodule

bind add_rotate_cbc_cipher arc_checker u_arc_checker (.*);

`default_nettype wire
